[hw/rtl/assert_macros.svh]
// Assertion helpers for the RTL. Each use sits on a line of its own.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off during reset.
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/xs64s_pkg.sv]
package xs64s_pkg;

	localparam logic [63:0] GOLDEN_GAMMA  = 64'h9E37_79B9_7F4A_7C15;
	localparam logic [63:0] MIX_MUL_A     = 64'hBF58_476D_1CE4_E5B9;
	localparam logic [63:0] MIX_MUL_B     = 64'h94D0_49BB_1331_11EB;
	localparam logic [63:0] SEED_OFFSET   = 64'hA076_1D64_78BD_642F;
	localparam logic [63:0] ZERO_FALLBACK = 64'h853C_49E6_748F_EA9B;
	localparam logic [63:0] STAR_MUL      = 64'h2545_F491_4F6C_DD1D;
	// Seed offset and splitmix increment folded into one add
	localparam logic [63:0] SEED_BIAS     = SEED_OFFSET + GOLDEN_GAMMA;

	localparam logic [31:0] SIGN_FLIP = 32'h8000_0000;

	localparam logic [2:0] KIND_SEED_RAW    = 3'd0;
	localparam logic [2:0] KIND_SEED_STREAM = 3'd1;
	localparam logic [2:0] KIND_DRAW64      = 3'd2;
	localparam logic [2:0] KIND_DRAW32      = 3'd3;
	localparam logic [2:0] KIND_FRACTION    = 3'd4;
	localparam logic [2:0] KIND_RANGE       = 3'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MIX0,
		ST_MUL,
		ST_POST,
		ST_MOD,
		ST_FIN,
		ST_OUT
	} fsm_t;

	// What the product in flight is for
	typedef enum logic [1:0] {
		MS_STREAM,
		MS_MIXA,
		MS_MIXB,
		MS_STAR
	} mstep_t;

	localparam logic [1:0] MUL_LAST = 2'd3;
	localparam logic [4:0] DIV_LAST = 5'd31;

endpackage

[hw/rtl/xorshift64star_rng_with_seeding.sv]
// Channel | Signals                                               | Transfer
// in      | in_valid, in_ready, req_type, seed_value, stream_seed, | in_valid & in_ready
//         | stream_index, range_low, range_high                    |
// out     | out_valid, out_ready, draw_value, range_value          | out_valid & out_ready
//
// One 32x32 multiplier builds each 64-bit product from three partial products;
// range draws add a restoring remainder loop, one bit a cycle, and an empty
// range goes straight to the output step. in_ready is high only when idle.
// The result sits in an output register; a stalled output holds the next result
// in the last step and takes no request meanwhile; a reseed can still run while
// only the output register holds a result. Reset loads the fallback state.
`include "assert_macros.svh"

module xorshift64star_rng_with_seeding import xs64s_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         req_type,
	input  logic [63:0]        seed_value,
	input  logic [31:0]        stream_seed,
	input  logic [31:0]        stream_index,
	input  logic signed [31:0] range_low,
	input  logic signed [31:0] range_high,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [63:0]        draw_value,
	output logic signed [31:0] range_value
);

	fsm_t        fsm_q, fsm_d;
	mstep_t      mstep_q;
	logic [1:0]  mcnt_q;
	logic [2:0]  kind_q;
	logic [63:0] gen_state_q;
	logic [63:0] z_q, ma_q, mb_q, acc_q, prod_s1;
	logic [31:0] code_q, lo_q, span_q, dvd_q, rem_q;
	logic [4:0]  dcnt_q;
	logic [63:0] res_draw_q, out_draw_q;
	logic [31:0] res_range_q, out_range_q;
	logic        out_valid_q;

	logic        in_xfer, load_out, range_empty, draw_kind;
	logic [63:0] x_a, x_b, x_next, mix_out;
	logic [31:0] op_a, op_b;
	logic [63:0] mul_p;
	logic [32:0] rem_shift, rem_sub;
	logic [31:0] rem_next;

	assign in_ready    = (fsm_q == ST_IDLE);
	assign in_xfer     = in_valid & in_ready;
	assign out_valid   = out_valid_q;
	assign draw_value  = out_draw_q;
	assign range_value = out_range_q;
	assign load_out    = (fsm_q == ST_OUT) && (!out_valid_q || out_ready);

	// xorshift step on the live state
	assign x_a    = gen_state_q ^ (gen_state_q >> 12);
	assign x_b    = x_a ^ (x_a << 25);
	assign x_next = x_b ^ (x_b >> 27);

	assign range_empty = (32'(range_high) ^ SIGN_FLIP) <= (32'(range_low) ^ SIGN_FLIP);
	assign draw_kind   = (req_type == KIND_DRAW64) || (req_type == KIND_DRAW32)
		|| (req_type == KIND_FRACTION) || ((req_type == KIND_RANGE) && !range_empty);

	assign mix_out = acc_q ^ (acc_q >> 31);

	// Partial products: lo*lo, lo*hi, hi*lo (hi*hi falls off the top)
	always_comb begin
		case (mcnt_q)
			2'd0: begin
				op_a = ma_q[31:0];
				op_b = mb_q[31:0];
			end
			2'd1: begin
				op_a = ma_q[31:0];
				op_b = mb_q[63:32];
			end
			2'd2: begin
				op_a = ma_q[63:32];
				op_b = mb_q[31:0];
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end
	assign mul_p = {32'b0, op_a} * {32'b0, op_b};

	// Restoring remainder step
	assign rem_shift = {rem_q, dvd_q[31]};
	assign rem_sub   = rem_shift - {1'b0, span_q};
	assign rem_next  = rem_sub[32] ? rem_shift[31:0] : rem_sub[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q <= ST_IDLE;
		end else begin
			fsm_q <= fsm_d;
		end
	end

	always_comb begin
		fsm_d = fsm_q;
		case (fsm_q)
			ST_IDLE: begin
				if (in_xfer) begin
					case (req_type)
						KIND_SEED_RAW:    fsm_d = ST_MIX0;
						KIND_SEED_STREAM: fsm_d = ST_MUL;
						KIND_DRAW64:      fsm_d = ST_MUL;
						KIND_DRAW32:      fsm_d = ST_MUL;
						KIND_FRACTION:    fsm_d = ST_MUL;
						KIND_RANGE:       fsm_d = range_empty ? ST_OUT : ST_MUL;
						default:          fsm_d = ST_IDLE;
					endcase
				end
			end
			ST_MIX0: fsm_d = ST_MUL;
			ST_MUL: begin
				if (mcnt_q == MUL_LAST) begin
					fsm_d = ST_POST;
				end
			end
			ST_POST: begin
				case (mstep_q)
					MS_STREAM: fsm_d = ST_MIX0;
					MS_MIXA:   fsm_d = ST_MUL;
					MS_MIXB:   fsm_d = ST_IDLE;
					MS_STAR: begin
						if (kind_q == KIND_RANGE) begin
							fsm_d = (span_q == '0) ? ST_FIN : ST_MOD;
						end else begin
							fsm_d = ST_OUT;
						end
					end
					default:   fsm_d = ST_IDLE;
				endcase
			end
			ST_MOD: begin
				if (dcnt_q == '0) begin
					fsm_d = ST_FIN;
				end
			end
			ST_FIN: fsm_d = ST_OUT;
			ST_OUT: begin
				if (load_out) begin
					fsm_d = ST_IDLE;
				end
			end
			default: fsm_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mcnt_q      <= '0;
			out_valid_q <= 1'b0;
			gen_state_q <= ZERO_FALLBACK;
		end else begin
			mcnt_q <= (fsm_q == ST_MUL) ? mcnt_q + 2'd1 : 2'd0;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (in_xfer && draw_kind) begin
				gen_state_q <= x_next;
			end else if (fsm_q == ST_POST && mstep_q == MS_MIXB) begin
				gen_state_q <= (mix_out == '0) ? ZERO_FALLBACK : mix_out;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (fsm_q)
			ST_IDLE: begin
				if (in_xfer) begin
					kind_q      <= req_type;
					code_q      <= stream_seed;
					lo_q        <= 32'(range_low);
					span_q      <= 32'(range_high) - 32'(range_low) + 32'd1;
					z_q         <= seed_value + SEED_BIAS;
					res_draw_q  <= '0;
					res_range_q <= 32'(range_low);
					if (req_type == KIND_SEED_STREAM) begin
						ma_q    <= GOLDEN_GAMMA;
						mb_q    <= {32'b0, stream_index + 32'd1};
						mstep_q <= MS_STREAM;
					end else begin
						ma_q    <= x_next;
						mb_q    <= STAR_MUL;
						mstep_q <= MS_STAR;
					end
				end
			end
			ST_MIX0: begin
				ma_q    <= z_q ^ (z_q >> 30);
				mb_q    <= MIX_MUL_A;
				mstep_q <= MS_MIXA;
			end
			ST_MUL: begin
				prod_s1 <= mul_p;
				if (mcnt_q == 2'd1) begin
					acc_q <= prod_s1;
				end else if (mcnt_q != 2'd0) begin
					acc_q[63:32] <= acc_q[63:32] + prod_s1[31:0];
				end
			end
			ST_POST: begin
				case (mstep_q)
					MS_STREAM: begin
						z_q <= (({32'b0, code_q} << 20) ^ acc_q) + SEED_BIAS;
					end
					MS_MIXA: begin
						ma_q    <= acc_q ^ (acc_q >> 27);
						mb_q    <= MIX_MUL_B;
						mstep_q <= MS_MIXB;
					end
					MS_STAR: begin
						res_range_q <= '0;
						dvd_q       <= acc_q[63:32];
						dcnt_q      <= DIV_LAST;
						// full span: take the raw top word
						rem_q       <= (span_q == '0) ? acc_q[63:32] : 32'd0;
						case (kind_q)
							KIND_DRAW64:   res_draw_q <= acc_q;
							KIND_DRAW32:   res_draw_q <= {32'b0, acc_q[63:32]};
							KIND_FRACTION: res_draw_q <= {40'b0, acc_q[63:40]};
							default:       res_draw_q <= '0;
						endcase
					end
					default: begin
					end
				endcase
			end
			ST_MOD: begin
				rem_q  <= rem_next;
				dvd_q  <= dvd_q << 1;
				dcnt_q <= dcnt_q - 5'd1;
			end
			ST_FIN: begin
				res_range_q <= lo_q + rem_q;
			end
			ST_OUT: begin
				if (load_out) begin
					out_draw_q  <= res_draw_q;
					out_range_q <= res_range_q;
				end
			end
			default: begin
			end
		endcase
	end

	`ASSERT_IMP(a_state_nonzero, clk, arst_n, 1'b1, gen_state_q != '0, "generator state is zero")
	`ASSERT_IMP(a_mcnt_in_mul, clk, arst_n, mcnt_q != 2'd0, fsm_q == ST_MUL, "mul count outside multiply")
	`ASSERT_IMP(a_rem_below_span, clk, arst_n, fsm_q == ST_MOD, rem_q < span_q, "remainder not below span")
	`ASSERT_NXT(a_out_hold, clk, arst_n, fsm_q == ST_OUT && out_valid_q && !out_ready, fsm_q == ST_OUT, "result dropped while output stalled")

endmodule

[sim/xorshift64star_rng_with_seeding_test.sv]
`timescale 1ns / 100ps

module xorshift64star_rng_with_seeding_test import xs64s_pkg::*; ();

	localparam logic [2:0] KIND_IGNORED_LO = 3'd6;
	localparam logic [2:0] KIND_IGNORED_HI = 3'd7;
	localparam logic [31:0] RANGE_MIN = 32'h8000_0000;
	localparam logic [31:0] RANGE_MAX = 32'h7FFF_FFFF;
	localparam int SEED_SETTLE_CYCLES = 40;

	typedef struct packed {
		logic [63:0] draw;
		logic [31:0] bounded;
	} rng_result_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [2:0] req_type;
	logic [63:0] seed_value;
	logic [31:0] stream_seed;
	logic [31:0] stream_index;
	logic signed [31:0] range_low;
	logic signed [31:0] range_high;
	logic out_valid;
	logic out_ready;
	logic [63:0] draw_value;
	logic signed [31:0] range_value;

	logic [63:0] shadow_state;
	rng_result_t pending_results[$];
	rng_result_t oldest_result;
	int error_count = 0;
	int sender_gap_pct = 0;
	bit steady_phase = 1'b0;

	xorshift64star_rng_with_seeding dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.seed_value(seed_value),
		.stream_seed(stream_seed),
		.stream_index(stream_index),
		.range_low(range_low),
		.range_high(range_high),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.draw_value(draw_value),
		.range_value(range_value)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#15_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic logic [63:0] splitmix_scramble(input logic [63:0] v);
		logic [63:0] z;
		z = v + GOLDEN_GAMMA;
		z = (z ^ (z >> 30)) * MIX_MUL_A;
		z = (z ^ (z >> 27)) * MIX_MUL_B;
		return z ^ (z >> 31);
	endfunction

	function automatic void load_seed(input logic [63:0] seed);
		logic [63:0] s;
		s = splitmix_scramble(seed + SEED_OFFSET);
		shadow_state = (s == 64'd0) ? ZERO_FALLBACK : s;
	endfunction

	function automatic logic [63:0] xorshift_advance();
		logic [63:0] x;
		x = shadow_state;
		x = x ^ (x >> 12);
		x = x ^ (x << 25);
		x = x ^ (x >> 27);
		shadow_state = x;
		return x * STAR_MUL;
	endfunction

	// Update the shadow state for one accepted request and queue its result, if any.
	function automatic void predict_request(input logic [2:0] kind, input logic [63:0] seed,
			input logic [31:0] code, input logic [31:0] idx, input logic [31:0] lo,
			input logic [31:0] hi);
		rng_result_t res;
		logic [31:0] idx1;
		logic [31:0] span;
		logic [31:0] r32;
		res = '0;
		case (kind)
			KIND_SEED_RAW: begin
				load_seed(seed);
				return;
			end
			KIND_SEED_STREAM: begin
				idx1 = idx + 32'd1;
				load_seed(({32'd0, code} << 20) ^ (GOLDEN_GAMMA * {32'd0, idx1}));
				return;
			end
			KIND_DRAW64: res.draw = xorshift_advance();
			KIND_DRAW32: res.draw = xorshift_advance() >> 32;
			KIND_FRACTION: res.draw = xorshift_advance() >> 40;
			KIND_RANGE: begin
				if ($signed(hi) <= $signed(lo)) begin
					res.bounded = lo;
				end else begin
					span = hi - lo + 32'd1;
					r32 = 32'(xorshift_advance() >> 32);
					// a full 32-bit range wraps the span to zero: take the draw as is
					res.bounded = lo + ((span == 32'd0) ? r32 : (r32 % span));
				end
			end
			default: return;
		endcase
		pending_results.push_back(res);
	endfunction

	task automatic send_request(input logic [2:0] kind, input logic [63:0] seed,
			input logic [31:0] code, input logic [31:0] idx, input logic [31:0] lo,
			input logic [31:0] hi);
		if (sender_gap_pct != 0 && $urandom_range(0, 99) < sender_gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		seed_value <= seed;
		stream_seed <= code;
		stream_index <= idx;
		range_low <= lo;
		range_high <= hi;
		do @(posedge clk); while (!in_ready);
		predict_request(kind, seed, code, idx, lo, hi);
	endtask

	task automatic send_random_request();
		logic [2:0] kind;
		logic [31:0] lo;
		logic [31:0] hi;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 8)
			kind = KIND_SEED_RAW;
		else if (pick < 16)
			kind = KIND_SEED_STREAM;
		else if (pick < 32)
			kind = KIND_DRAW64;
		else if (pick < 48)
			kind = KIND_DRAW32;
		else if (pick < 64)
			kind = KIND_FRACTION;
		else if (pick < 98)
			kind = KIND_RANGE;
		else
			kind = pick[0] ? KIND_IGNORED_HI : KIND_IGNORED_LO;
		lo = $urandom;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: hi = lo + $urandom_range(1, 1000);
			5, 6: hi = $urandom;
			7: hi = lo - $urandom_range(0, 5);
			8: begin
				lo = RANGE_MIN + $urandom_range(0, 3);
				hi = RANGE_MAX - $urandom_range(0, 3);
			end
			default: hi = lo + (32'd1 << $urandom_range(0, 30)) - 32'd1;
		endcase
		send_request(kind, {$urandom, $urandom}, $urandom, $urandom, lo, hi);
	endtask

	task automatic pause_until_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		// a reseed in flight gives no result: let it finish
		repeat (SEED_SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic test_reset_state();
		send_request(KIND_DRAW64, 64'd0, 32'd0, 32'd0, 32'd0, 32'd0);
		send_request(KIND_DRAW32, 64'd0, 32'd0, 32'd0, 32'd0, 32'd0);
	endtask

	task automatic test_draw_kinds();
		send_request(KIND_DRAW64, '1, '1, '1, '1, '1);
		send_request(KIND_DRAW32, '1, '1, '1, '1, '1);
		send_request(KIND_FRACTION, 64'd0, 32'd0, 32'd0, 32'd0, 32'd0);
	endtask

	task automatic test_seeding();
		send_request(KIND_SEED_RAW, 64'd0, 32'd0, 32'd0, 32'd0, 32'd0);
		send_request(KIND_DRAW64, 64'd0, 32'd0, 32'd0, 32'd0, 32'd0);
		send_request(KIND_SEED_RAW, '1, 32'd0, 32'd0, 32'd0, 32'd0);
		send_request(KIND_DRAW32, 64'd0, 32'd0, 32'd0, 32'd0, 32'd0);
		// this seed mixes to zero and must fall back to the constant
		send_request(KIND_SEED_RAW, 64'd0 - SEED_BIAS, 32'd0, 32'd0, 32'd0, 32'd0);
		send_request(KIND_DRAW64, 64'd0, 32'd0, 32'd0, 32'd0, 32'd0);
		send_request(KIND_SEED_STREAM, 64'd0, 32'd0, 32'd0, 32'd0, 32'd0);
		send_request(KIND_DRAW64, 64'd0, 32'd0, 32'd0, 32'd0, 32'd0);
		// index plus one wraps to zero here
		send_request(KIND_SEED_STREAM, 64'd0, '1, '1, 32'd0, 32'd0);
		send_request(KIND_FRACTION, 64'd0, 32'd0, 32'd0, 32'd0, 32'd0);
	endtask

	task automatic test_range_cases();
		send_request(KIND_RANGE, 64'd0, 32'd0, 32'd0, 32'd7, 32'd7);
		send_request(KIND_RANGE, 64'd0, 32'd0, 32'd0, RANGE_MAX, RANGE_MIN);
		send_request(KIND_RANGE, 64'd0, 32'd0, 32'd0, RANGE_MIN, RANGE_MAX);
		send_request(KIND_RANGE, 64'd0, 32'd0, 32'd0, RANGE_MIN, RANGE_MIN + 32'd1);
		send_request(KIND_RANGE, 64'd0, 32'd0, 32'd0, RANGE_MAX - 32'd1, RANGE_MAX);
		send_request(KIND_RANGE, 64'd0, 32'd0, 32'd0, -32'sd5, 32'sd5);
		send_request(KIND_RANGE, 64'd0, 32'd0, 32'd0, 32'd0, 32'hFFFF);
	endtask

	task automatic test_ignored_kinds();
		send_request(KIND_IGNORED_LO, '1, '1, '1, '1, '1);
		send_request(KIND_IGNORED_HI, '1, '1, '1, 32'd0, 32'd9);
		send_request(KIND_DRAW64, 64'd0, 32'd0, 32'd0, 32'd0, 32'd0);
	endtask

	task automatic test_random_traffic(input int count, input int gap_pct);
		sender_gap_pct = gap_pct;
		repeat (count) send_random_request();
	endtask

	task automatic test_drained_pause();
		sender_gap_pct = 20;
		repeat (50) send_random_request();
		pause_until_drained();
		repeat (50) send_random_request();
	endtask

	task automatic test_steady_traffic(input int count);
		steady_phase = 1'b1;
		sender_gap_pct = 0;
		repeat (count) send_random_request();
	endtask

	// Receiver: stall in random bursts until the steady phase.
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!steady_phase && $urandom_range(0, 99) < 15) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				error_count++;
				$display("%0t: unexpected result, expected none, actual draw %h range %h",
					$time, draw_value, range_value);
			end else begin
				oldest_result = pending_results.pop_front();
				if (draw_value !== oldest_result.draw) begin
					error_count++;
					$display("%0t: draw_value mismatch, expected %h, actual %h",
						$time, oldest_result.draw, draw_value);
				end
				if (range_value !== oldest_result.bounded) begin
					error_count++;
					$display("%0t: range_value mismatch, expected %h, actual %h",
						$time, oldest_result.bounded, range_value);
				end
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		req_type <= KIND_SEED_RAW;
		seed_value <= '0;
		stream_seed <= '0;
		stream_index <= '0;
		range_low <= '0;
		range_high <= '0;
		out_ready <= 1'b1;
		shadow_state = ZERO_FALLBACK;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_draw_kinds();
		test_seeding();
		test_range_cases();
		test_ignored_kinds();
		test_random_traffic(500, 25);
		test_random_traffic(300, 0);
		test_drained_pause();
		test_random_traffic(300, 40);
		test_steady_traffic(250);

		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
